[rtl/core/pbce_pkg.sv]
// Package for the plotter binary command encoder.
// Holds op codes, command byte constants and the byte packing helpers.
// No dependencies.
`timescale 1ns / 1ps

package pbce_pkg;

  localparam logic [2:0] OP_MOVE  = 3'd0;
  localparam logic [2:0] OP_DRAW  = 3'd1;
  localparam logic [2:0] OP_DOT   = 3'd2;
  localparam logic [2:0] OP_PEN   = 3'd3;
  localparam logic [2:0] OP_SPEED = 3'd4;

  localparam logic [6:0] CMD_MOVE   = 7'h70;
  localparam logic [6:0] CMD_DRAW   = 7'h71;
  localparam logic [6:0] CMD_PEN    = 7'h76;
  localparam logic [6:0] CMD_ESCAPE = 7'h7E;
  localparam logic [6:0] CMD_SPEED  = 7'h56;

  localparam logic [6:0] LEAD_BIAS = 7'd96;
  localparam logic [5:0] SPEED_MAX = 6'd36;
  localparam logic [2:0] PEN_MAX   = 3'd4;
  localparam logic [2:0] PEN_DFLT  = 3'd1;

  // single-byte number: low six bits, plus 64 when below 32
  function automatic logic [6:0] sbn(input logic [5:0] n);
    sbn = {~n[5], n};
  endfunction

  // lead byte of a coordinate pair
  function automatic logic [6:0] lead(input logic [3:0] v);
    lead = LEAD_BIAS + {3'b000, v};
  endfunction

endpackage

[rtl/core/plotter_binary_command_encoder_unit.sv]
// Top level of the plotter binary command encoder.
// Depends on pbce_pkg for op codes, command bytes and packing helpers.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. It then produces its
// bytes one per clock cycle, each shown for one cycle with out_strobe high and
// out_last_byte high on the final one: 2 bytes for move or draw with small
// coordinates up to 6, up to 18 for a dot, 2 for pen select, 3 for set speed.
// The command is registered, then its first byte at the outputs. busy drops in
// the cycle that produces the final byte, so the next command can follow with
// no gap in the byte stream. Op codes 5 to 7 produce no bytes. The receiver
// must take every byte as it comes; there is no way to hold the output.
module plotter_binary_command_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [13:0] in_x_coord,
  input  logic [13:0] in_y_coord,
  input  logic [2:0]  in_pen_number,
  input  logic [5:0]  in_speed_value,
  output logic        out_strobe,
  output logic [6:0]  out_data_byte,
  output logic        out_last_byte
);

  logic        act_r, act_nxt;
  logic [1:0]  seg_r, seg_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [13:0] x_r, x_nxt;
  logic [13:0] y_r, y_nxt;
  logic [2:0]  pen_r, pen_nxt;
  logic [5:0]  spd_r, spd_nxt;
  logic        strobe_r, strobe_nxt;
  logic [6:0]  data_r, data_nxt;
  logic        last_r, last_nxt;

  logic        accept;
  logic [13:0] m;
  logic [2:0]  plen;
  logic [6:0]  pb [5];
  logic [6:0]  cmd;
  logic [6:0]  cur_byte;
  logic        sub_last;
  logic        seg_last;
  logic        fin;
  logic [2:0]  pen_c;
  logic [5:0]  spd_c;

  // pack the held coordinate pair
  always_comb begin
    m = (y_r > x_r) ? y_r : x_r;
    for (int i = 0; i < 5; i++) begin
      pb[i] = 7'd0;
    end
    if (m < 14'd4) begin
      plen  = 3'd1;
      pb[0] = pbce_pkg::LEAD_BIAS + {3'b000, x_r[1:0], y_r[1:0]};
    end else if (m < 14'd32) begin
      plen  = 3'd2;
      pb[0] = pbce_pkg::lead(x_r[4:1]);
      pb[1] = pbce_pkg::sbn({x_r[0], y_r[4:0]});
    end else if (m < 14'd256) begin
      plen  = 3'd3;
      pb[0] = pbce_pkg::lead(x_r[7:4]);
      pb[1] = pbce_pkg::sbn({x_r[3:0], y_r[7:6]});
      pb[2] = pbce_pkg::sbn(y_r[5:0]);
    end else if (m < 14'd2048) begin
      plen  = 3'd4;
      pb[0] = pbce_pkg::lead(x_r[10:7]);
      pb[1] = pbce_pkg::sbn(x_r[6:1]);
      pb[2] = pbce_pkg::sbn({x_r[0], y_r[10:6]});
      pb[3] = pbce_pkg::sbn(y_r[5:0]);
    end else begin
      plen  = 3'd5;
      pb[0] = pbce_pkg::lead(x_r[13:10]);
      pb[1] = pbce_pkg::sbn(x_r[9:4]);
      pb[2] = pbce_pkg::sbn({x_r[3:0], y_r[13:12]});
      pb[3] = pbce_pkg::sbn(y_r[11:6]);
      pb[4] = pbce_pkg::sbn(y_r[5:0]);
    end
  end

  // select the current byte
  always_comb begin
    cmd      = pbce_pkg::CMD_MOVE;
    cur_byte = 7'd0;
    sub_last = 1'b1;
    seg_last = 1'b1;
    case (op_r)
      pbce_pkg::OP_MOVE, pbce_pkg::OP_DRAW, pbce_pkg::OP_DOT: begin
        if (op_r == pbce_pkg::OP_DRAW) begin
          cmd = pbce_pkg::CMD_DRAW;
        end else if (op_r == pbce_pkg::OP_DOT && seg_r == 2'd1) begin
          cmd = pbce_pkg::CMD_DRAW;
        end
        case (sub_r)
          3'd0:    cur_byte = cmd;
          3'd1:    cur_byte = pb[0];
          3'd2:    cur_byte = pb[1];
          3'd3:    cur_byte = pb[2];
          3'd4:    cur_byte = pb[3];
          3'd5:    cur_byte = pb[4];
          default: cur_byte = 7'd0;
        endcase
        sub_last = (sub_r == plen);
        seg_last = (op_r != pbce_pkg::OP_DOT) || (seg_r == 2'd2);
      end
      pbce_pkg::OP_PEN: begin
        cur_byte = (sub_r == 3'd0) ? pbce_pkg::CMD_PEN : pbce_pkg::sbn({3'b000, pen_r});
        sub_last = (sub_r == 3'd1);
      end
      pbce_pkg::OP_SPEED: begin
        case (sub_r)
          3'd0:    cur_byte = pbce_pkg::CMD_ESCAPE;
          3'd1:    cur_byte = pbce_pkg::CMD_SPEED;
          default: cur_byte = pbce_pkg::sbn(spd_r);
        endcase
        sub_last = (sub_r == 3'd2);
      end
      default: begin
        cur_byte = 7'd0;
      end
    endcase
    fin = sub_last && seg_last;
  end

  assign busy   = act_r && !fin;
  assign accept = start && !busy;

  // clamp speed to 1..SPEED_MAX, default an out-of-range pen, on the way in
  always_comb begin
    pen_c = (in_pen_number > pbce_pkg::PEN_MAX) ? pbce_pkg::PEN_DFLT : in_pen_number;
    if (in_speed_value > pbce_pkg::SPEED_MAX) begin
      spd_c = pbce_pkg::SPEED_MAX;
    end else if (in_speed_value == 6'd0) begin
      spd_c = 6'd1;
    end else begin
      spd_c = in_speed_value;
    end
  end

  // sequencing
  always_comb begin
    act_nxt = act_r;
    seg_nxt = seg_r;
    sub_nxt = sub_r;
    op_nxt  = op_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    pen_nxt = pen_r;
    spd_nxt = spd_r;
    if (accept) begin
      act_nxt = (in_op <= pbce_pkg::OP_SPEED);
      seg_nxt = 2'd0;
      sub_nxt = 3'd0;
      op_nxt  = in_op;
      x_nxt   = in_x_coord;
      y_nxt   = in_y_coord;
      pen_nxt = pen_c;
      spd_nxt = spd_c;
    end else if (act_r) begin
      if (fin) begin
        act_nxt = 1'b0;
      end else if (sub_last) begin
        sub_nxt = 3'd0;
        seg_nxt = seg_r + 2'd1;
      end else begin
        sub_nxt = sub_r + 3'd1;
      end
    end
    strobe_nxt = act_r;
    data_nxt   = cur_byte;
    last_nxt   = act_r && fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      seg_r    <= 2'd0;
      sub_r    <= 3'd0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      seg_r    <= seg_nxt;
      sub_r    <= sub_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    pen_r  <= pen_nxt;
    spd_r  <= spd_nxt;
    data_r <= data_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_data_byte = data_r;
  assign out_last_byte = last_r;

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op <= pbce_pkg::OP_SPEED) |-> ##2 out_strobe)
    else $error("accepted transaction produced no first byte");

  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !out_last_byte))
    else $error("busy without a non-final byte following");

  a_mid_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_byte) |-> $past(busy))
    else $error("non-final byte while not busy");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_byte) |=> !(out_strobe && !out_last_byte && !$past(busy)))
    else $error("byte stream continued after final byte without a new transaction");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for plotter_binary_command_encoder_unit.
// Drives directed and random commands, predicts every byte and checks the output stream.
// Depends on pbce_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;

  typedef struct {
    logic [2:0]  op;
    logic [13:0] x;
    logic [13:0] y;
    logic [2:0]  pen;
    logic [5:0]  spd;
  } plot_cmd_t;

  typedef struct {
    logic [6:0] data;
    logic       last;
  } plot_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [13:0] in_x_coord = '0;
  logic [13:0] in_y_coord = '0;
  logic [2:0]  in_pen_number = '0;
  logic [5:0]  in_speed_value = '0;
  logic        out_strobe;
  logic [6:0]  out_data_byte;
  logic        out_last_byte;

  plot_cmd_t  cmd_queue[$];
  plot_byte_t bytes_due[$];
  plot_byte_t cmd_bytes[$];
  int         idle_pct = 26;
  logic       hold_off = 1'b0;
  int         mismatches = 0;

  plotter_binary_command_encoder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .in_pen_number(in_pen_number),
    .in_speed_value(in_speed_value),
    .out_strobe(out_strobe),
    .out_data_byte(out_data_byte),
    .out_last_byte(out_last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // byte predictor
  function automatic void put_raw(input logic [6:0] b);
    plot_byte_t e;
    e.data = b;
    e.last = 1'b0;
    cmd_bytes.push_back(e);
  endfunction

  function automatic void put_number(input logic [13:0] n);
    logic [6:0] v;
    v = {1'b0, n[5:0]};
    if (v < 7'd32) v = v + 7'd64;
    put_raw(v);
  endfunction

  function automatic void put_coords(input logic [13:0] x, input logic [13:0] y);
    logic [13:0] m;
    m = (y > x) ? y : x;
    if (m < 14'd4) begin
      put_raw(pbce_pkg::LEAD_BIAS + {3'b000, x[1:0], y[1:0]});
    end else if (m < 14'd32) begin
      put_raw(pbce_pkg::LEAD_BIAS + 7'(x >> 1));
      put_number(y + ((x & 14'd1) << 5));
    end else if (m < 14'd256) begin
      put_raw(pbce_pkg::LEAD_BIAS + 7'(x >> 4));
      put_number((y >> 6) + ((x & 14'd15) << 2));
      put_number(y & 14'd63);
    end else if (m < 14'd2048) begin
      put_raw(pbce_pkg::LEAD_BIAS + 7'(x >> 7));
      put_number((x >> 1) & 14'd63);
      put_number((y >> 6) + ((x & 14'd1) << 5));
      put_number(y & 14'd63);
    end else begin
      put_raw(pbce_pkg::LEAD_BIAS + 7'(x >> 10));
      put_number((x & 14'd1023) >> 4);
      put_number((y >> 12) + ((x & 14'd15) << 2));
      put_number((y & 14'd4095) >> 6);
      put_number(y & 14'd63);
    end
  endfunction

  function automatic void predict_bytes(input plot_cmd_t c);
    logic [2:0] pen;
    logic [5:0] spd;
    plot_byte_t e;
    cmd_bytes.delete();
    pen = c.pen;
    spd = c.spd;
    case (c.op)
      pbce_pkg::OP_MOVE: begin
        put_raw(pbce_pkg::CMD_MOVE);
        put_coords(c.x, c.y);
      end
      pbce_pkg::OP_DRAW: begin
        put_raw(pbce_pkg::CMD_DRAW);
        put_coords(c.x, c.y);
      end
      pbce_pkg::OP_DOT: begin
        put_raw(pbce_pkg::CMD_MOVE);
        put_coords(c.x, c.y);
        put_raw(pbce_pkg::CMD_DRAW);
        put_coords(c.x, c.y);
        put_raw(pbce_pkg::CMD_MOVE);
        put_coords(c.x, c.y);
      end
      pbce_pkg::OP_PEN: begin
        if (pen > pbce_pkg::PEN_MAX) pen = pbce_pkg::PEN_DFLT;
        put_raw(pbce_pkg::CMD_PEN);
        put_number({11'd0, pen});
      end
      pbce_pkg::OP_SPEED: begin
        if (spd > pbce_pkg::SPEED_MAX) spd = pbce_pkg::SPEED_MAX;
        if (spd == 6'd0) spd = 6'd1;
        put_raw(pbce_pkg::CMD_ESCAPE);
        put_raw(pbce_pkg::CMD_SPEED);
        put_number({8'd0, spd});
      end
      default: ;
    endcase
    if (cmd_bytes.size() > 0) begin
      e = cmd_bytes.pop_back();
      e.last = 1'b1;
      cmd_bytes.push_back(e);
    end
    foreach (cmd_bytes[i]) bytes_due.push_back(cmd_bytes[i]);
  endfunction

  // driver: hold a command until taken, then advance or idle
  always @(posedge clk) begin
    plot_cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (!hold_off && cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        in_op          <= c.op;
        in_x_coord     <= c.x;
        in_y_coord     <= c.y;
        in_pen_number  <= c.pen;
        in_speed_value <= c.spd;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // input monitor: predict on every accepted transaction
  always @(posedge clk) begin
    plot_cmd_t c;
    if (rst_n && start && !busy) begin
      c.op  = in_op;
      c.x   = in_x_coord;
      c.y   = in_y_coord;
      c.pen = in_pen_number;
      c.spd = in_speed_value;
      predict_bytes(c);
    end
  end

  // output monitor
  always @(posedge clk) begin
    plot_byte_t e;
    if (rst_n && out_strobe) begin
      if (bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h last %b", out_data_byte, out_last_byte));
      end else begin
        e = bytes_due.pop_front();
        if (out_data_byte !== e.data) begin
          flag_mismatch($sformatf("data_byte %h, expected %h", out_data_byte, e.data));
        end
        if (out_last_byte !== e.last) begin
          flag_mismatch($sformatf("last_byte %b, expected %b", out_last_byte, e.last));
        end
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [13:0] x, input logic [13:0] y,
                         input logic [2:0] pen, input logic [5:0] spd);
    plot_cmd_t c;
    c.op  = op;
    c.x   = x;
    c.y   = y;
    c.pen = pen;
    c.spd = spd;
    cmd_queue.push_back(c);
  endtask

  task automatic add_random_cmds(input int count);
    int made;
    int cls;
    logic [13:0] class_hi[5];
    logic [13:0] lo;
    logic [13:0] m;
    logic [13:0] other;
    plot_cmd_t c;
    made = 0;
    class_hi = '{14'd3, 14'd31, 14'd255, 14'd2047, 14'd16383};
    while (made < count) begin
      if ($urandom_range(99) < 5) begin
        c.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end else begin
        c.op = 3'($urandom_range(pbce_pkg::OP_SPEED, pbce_pkg::OP_MOVE));
      end
      cls = $urandom_range(5);
      if (cls == 5) begin
        c.x = 14'($urandom);
        c.y = 14'($urandom);
      end else begin
        lo = (cls == 0) ? 14'd0 : class_hi[cls - 1] + 14'd1;
        m = 14'($urandom_range(class_hi[cls], lo));
        other = 14'($urandom_range(class_hi[cls]));
        if ($urandom_range(1) == 1) begin
          c.x = m;
          c.y = other;
        end else begin
          c.x = other;
          c.y = m;
        end
      end
      c.pen = 3'($urandom);
      c.spd = 6'($urandom);
      cmd_queue.push_back(c);
      if (c.op <= pbce_pkg::OP_SPEED) made++;
    end
  endtask

  // wait for the sender to go quiet and every predicted byte to arrive
  task automatic settle();
    int n;
    while (start) @(posedge clk);
    n = 0;
    while (bytes_due.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (bytes_due.size() > 0) begin
      flag_mismatch($sformatf("%0d expected bytes never arrived", bytes_due.size()));
      bytes_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // coordinate packing classes at their edges
    add_cmd(pbce_pkg::OP_MOVE, 14'd0, 14'd0, 3'd7, 6'd63);
    add_cmd(pbce_pkg::OP_DRAW, 14'd3, 14'd3, 3'd0, 6'd0);
    add_cmd(pbce_pkg::OP_MOVE, 14'd31, 14'd5, 3'd5, 6'd21);
    add_cmd(pbce_pkg::OP_DRAW, 14'd4, 14'd31, 3'd2, 6'd40);
    add_cmd(pbce_pkg::OP_MOVE, 14'd255, 14'd200, 3'd6, 6'd9);
    add_cmd(pbce_pkg::OP_DRAW, 14'd32, 14'd255, 3'd1, 6'd33);
    add_cmd(pbce_pkg::OP_MOVE, 14'd2047, 14'd1000, 3'd3, 6'd12);
    add_cmd(pbce_pkg::OP_DRAW, 14'd2048, 14'd0, 3'd4, 6'd50);
    add_cmd(pbce_pkg::OP_MOVE, 14'd16383, 14'd16383, 3'd0, 6'd1);
    add_cmd(pbce_pkg::OP_DOT, 14'd0, 14'd0, 3'd7, 6'd7);
    add_cmd(pbce_pkg::OP_DOT, 14'd16383, 14'd16383, 3'd2, 6'd63);
    add_cmd(pbce_pkg::OP_DOT, 14'd100, 14'd7, 3'd5, 6'd36);
    // pen range and out-of-range default
    add_cmd(pbce_pkg::OP_PEN, 14'd16383, 14'd0, 3'd0, 6'd63);
    add_cmd(pbce_pkg::OP_PEN, 14'd0, 14'd16383, 3'd1, 6'd0);
    add_cmd(pbce_pkg::OP_PEN, 14'd5461, 14'd10922, 3'd4, 6'd42);
    add_cmd(pbce_pkg::OP_PEN, 14'd10922, 14'd5461, 3'd5, 6'd21);
    add_cmd(pbce_pkg::OP_PEN, 14'd0, 14'd0, 3'd7, 6'd0);
    // speed clamp at both ends
    add_cmd(pbce_pkg::OP_SPEED, 14'd16383, 14'd16383, 3'd7, 6'd0);
    add_cmd(pbce_pkg::OP_SPEED, 14'd0, 14'd0, 3'd0, 6'd1);
    add_cmd(pbce_pkg::OP_SPEED, 14'd1, 14'd1, 3'd3, 6'd36);
    add_cmd(pbce_pkg::OP_SPEED, 14'd2, 14'd2, 3'd6, 6'd37);
    add_cmd(pbce_pkg::OP_SPEED, 14'd3, 14'd3, 3'd1, 6'd63);
    // unused op codes produce nothing
    add_cmd(OP_UNUSED_FIRST, 14'd16383, 14'd16383, 3'd7, 6'd63);
    add_cmd(OP_UNUSED_MID, 14'd100, 14'd100, 3'd2, 6'd10);
    add_cmd(OP_UNUSED_LAST, 14'd0, 14'd0, 3'd0, 6'd0);
    add_random_cmds(150);
    while (cmd_queue.size() > 0) @(posedge clk);
    settle();

    idle_pct <= 52;
    add_random_cmds(150);
    while (cmd_queue.size() > 75) @(posedge clk);
    hold_off <= 1'b1;
    settle();
    hold_off <= 1'b0;
    while (cmd_queue.size() > 0) @(posedge clk);
    settle();

    idle_pct <= 0;
    add_random_cmds(148);
    while (cmd_queue.size() > 0) @(posedge clk);
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pbce_pkg.sv
rtl/core/plotter_binary_command_encoder_unit.sv
verif/tb_top.sv
